// File: design/raid0_stripe_request_splitter_assert.svh
// assertion macros used by the splitter's piece module
`ifndef RAID0_STRIPE_REQUEST_SPLITTER_ASSERT_SVH
`define RAID0_STRIPE_REQUEST_SPLITTER_ASSERT_SVH

// same-cycle implication
`define R0SS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define R0SS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/r0ss_pkg.sv
`default_nettype none
package r0ss_pkg;

   localparam int LBLK_W      = 48;
   localparam int BYTES_W     = 17;
   localparam int PBLK_W      = 49;
   localparam int MIDX_W      = 4;
   localparam int SNO_W       = 45;
   localparam int OFFB_W      = 11;
   localparam int CNT_W       = 5;
   localparam int SHIFT_MIN   = 12;
   localparam int SHIFT_MAX   = 20;
   localparam int MAX_RESULTS = 17;
   localparam int STEP_BITS   = 3;
   localparam int DIV_STAGES  = (SNO_W + STEP_BITS - 1) / STEP_BITS;

   typedef enum logic [1:0] {
      CSR_STRIP_SHIFT  = 2'd0,
      CSR_MEMBER_COUNT = 2'd1,
      CSR_DATA_OFFSET  = 2'd2,
      CSR_ONLINE_MASK  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [4:0]  strip_shift;
      logic [4:0]  member_count;
      logic [31:0] data_offset_blocks;
      logic [15:0] member_online_mask;
   } cfg_type;

   typedef struct packed {
      logic [SNO_W-1:0]   num;
      logic [CNT_W-1:0]   rem;
      logic [CNT_W-1:0]   n;
      logic [4:0]         sh;
      logic [OFFB_W-1:0]  offb;
      logic [BYTES_W-1:0] left;
      logic               rd;
   } div_stage_type;

   typedef struct packed {
      logic [MIDX_W-1:0]  member_index;
      logic [PBLK_W-1:0]  physical_block;
      logic [BYTES_W-1:0] piece_bytes;
      logic               piece_is_read;
      logic               member_offline;
      logic               last_piece;
   } rsp_type;

endpackage
`default_nettype wire

// File: design/r0ss_chan_if.sv
`default_nettype none
interface r0ss_req_if;
   import r0ss_pkg::*;
   logic               valid;
   logic               ready;
   logic [LBLK_W-1:0]  logical_block;
   logic [BYTES_W-1:0] request_bytes;
   logic               is_read;
   modport source (output valid, logical_block, request_bytes, is_read, input ready);
   modport sink (input valid, logical_block, request_bytes, is_read, output ready);
endinterface

interface r0ss_rsp_if;
   import r0ss_pkg::*;
   logic               valid;
   logic               ready;
   logic [MIDX_W-1:0]  member_index;
   logic [PBLK_W-1:0]  physical_block;
   logic [BYTES_W-1:0] piece_bytes;
   logic               piece_is_read;
   logic               member_offline;
   logic               last_piece;
   modport source (output valid, member_index, physical_block, piece_bytes, piece_is_read,
                   member_offline, last_piece, input ready);
   modport sink (input valid, member_index, physical_block, piece_bytes, piece_is_read,
                 member_offline, last_piece, output ready);
endinterface
`default_nettype wire

// File: design/r0ss_csr.sv
`default_nettype none
module r0ss_csr
   import r0ss_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   cfg_type       cfg_ff, cfg_in;
   csr_index_type idx;
   logic          wr;

   assign idx        = csr_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            CSR_STRIP_SHIFT:  cfg_in.strip_shift        = csr_pwdata[4:0];
            CSR_MEMBER_COUNT: cfg_in.member_count       = csr_pwdata[4:0];
            CSR_DATA_OFFSET:  cfg_in.data_offset_blocks = csr_pwdata;
            CSR_ONLINE_MASK:  cfg_in.member_online_mask = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_STRIP_SHIFT:  csr_prdata = {27'd0, cfg_ff.strip_shift};
         CSR_MEMBER_COUNT: csr_prdata = {27'd0, cfg_ff.member_count};
         CSR_DATA_OFFSET:  csr_prdata = cfg_ff.data_offset_blocks;
         CSR_ONLINE_MASK:  csr_prdata = {16'd0, cfg_ff.member_online_mask};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strip_shift        <= 5'd16;
         cfg_ff.member_count       <= 5'd2;
         cfg_ff.data_offset_blocks <= 32'd0;
         cfg_ff.member_online_mask <= 16'hFFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// File: design/r0ss_div.sv
`default_nettype none
module r0ss_div
   import r0ss_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    adv,
   input  wire logic    in_valid,
   input  div_stage_type in_data,
   output logic          out_valid,
   output div_stage_type out_data
);

   // restoring division, STEP_BITS quotient bits per stage
   function automatic div_stage_type div_steps(div_stage_type s);
      div_stage_type     t;
      logic [CNT_W:0]    r;
      t = s;
      for (int i = 0; i < STEP_BITS; i++) begin
         r = {t.rem, t.num[SNO_W-1]};
         if (r >= {1'b0, t.n}) begin
            t.rem = CNT_W'(r - {1'b0, t.n});
            t.num = {t.num[SNO_W-2:0], 1'b1};
         end else begin
            t.rem = r[CNT_W-1:0];
            t.num = {t.num[SNO_W-2:0], 1'b0};
         end
      end
      return t;
   endfunction

   logic          valid_ff [DIV_STAGES];
   div_stage_type data_ff  [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) valid_ff[i] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DIV_STAGES; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff[0] <= div_steps(in_data);
         for (int i = 1; i < DIV_STAGES; i++) data_ff[i] <= div_steps(data_ff[i-1]);
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_data  = data_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: design/r0ss_piece.sv
`default_nettype none
module r0ss_piece
   import r0ss_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  cfg_type       cfg,
   input  wire logic    in_valid,
   input  div_stage_type in_data,
   output logic          in_ready,
   r0ss_rsp_if.source    rsp
);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   member_ff, member_in;
   logic [SNO_W-1:0]   row_ff, row_in;
   logic [OFFB_W-1:0]  offb_ff, offb_in;
   logic [BYTES_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [4:0]         sh_ff, sh_in;
   logic               rd_ff, rd_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;

   logic               step, online, last, load;
   logic [20:0]        strip_rem;
   logic [BYTES_W-1:0] len, left_rem;
   logic [PBLK_W-1:0]  row_blk, pblk;
   logic [CNT_W-1:0]   member_inc;

   always_comb begin
      step       = busy_ff && (!out_valid_ff || rsp.ready);
      online     = !member_ff[CNT_W-1] && cfg.member_online_mask[member_ff[MIDX_W-1:0]];
      strip_rem  = (21'd1 << sh_ff) - {1'b0, offb_ff, 9'd0};
      len        = (strip_rem > {4'd0, left_ff}) ? left_ff : strip_rem[BYTES_W-1:0];
      left_rem   = left_ff - len;
      last       = !online || (left_rem == '0) || (k_ff == CNT_W'(MAX_RESULTS - 1));
      row_blk    = PBLK_W'({4'd0, row_ff} << (sh_ff - 5'd9)) | PBLK_W'(offb_ff);
      pblk       = row_blk + PBLK_W'(cfg.data_offset_blocks);
      member_inc = member_ff + 5'd1;
      in_ready   = !busy_ff || (step && last);
      load       = in_valid && in_ready;
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp.ready;
      out_in       = out_ff;
      if (step) begin
         out_valid_in             = 1'b1;
         out_in.member_index      = member_ff[MIDX_W-1:0];
         out_in.physical_block    = pblk;
         out_in.piece_bytes       = online ? len : '0;
         out_in.piece_is_read     = rd_ff;
         out_in.member_offline    = !online;
         out_in.last_piece        = last;
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      member_in = member_ff;
      row_in    = row_ff;
      offb_in   = offb_ff;
      left_in   = left_ff;
      k_in      = k_ff;
      n_in      = n_ff;
      sh_in     = sh_ff;
      rd_in     = rd_ff;
      if (load) begin
         busy_in   = 1'b1;
         member_in = in_data.rem;
         row_in    = in_data.num;
         offb_in   = in_data.offb;
         left_in   = in_data.left;
         k_in      = '0;
         n_in      = in_data.n;
         sh_in     = in_data.sh;
         rd_in     = in_data.rd;
      end else if (step) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            left_in = left_rem;
            offb_in = '0;
            k_in    = k_ff + 5'd1;
            if (member_inc == n_ff) begin
               member_in = '0;
               row_in    = row_ff + 45'd1;
            end else begin
               member_in = member_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      member_ff <= member_in;
      row_ff    <= row_in;
      offb_ff   <= offb_in;
      left_ff   <= left_in;
      k_ff      <= k_in;
      n_ff      <= n_in;
      sh_ff     <= sh_in;
      rd_ff     <= rd_in;
      out_ff    <= out_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.member_index   = out_ff.member_index;
   assign rsp.physical_block = out_ff.physical_block;
   assign rsp.piece_bytes    = out_ff.piece_bytes;
   assign rsp.piece_is_read  = out_ff.piece_is_read;
   assign rsp.member_offline = out_ff.member_offline;
   assign rsp.last_piece     = out_ff.last_piece;

`include "raid0_stripe_request_splitter_assert.svh"
   `R0SS_ASSERT_IMP(a_err_is_last, out_valid_ff && out_ff.member_offline, out_ff.last_piece, "error beat not last")
   `R0SS_ASSERT_IMP(a_err_no_bytes, out_valid_ff && out_ff.member_offline, out_ff.piece_bytes == '0, "error beat carries bytes")
   `R0SS_ASSERT_IMP(a_count_bound, busy_ff, k_ff < CNT_W'(MAX_RESULTS), "piece count overrun")
   `R0SS_ASSERT_NXT(a_keep_busy, step && !last, busy_ff && out_valid_ff, "request dropped mid way")

endmodule
`default_nettype wire

// File: design/raid0_stripe_request_splitter.sv
//  channel | dir | beat
//  req     | in  | logical_block, request_bytes, is_read
//  rsp     | out | member_index, physical_block, piece_bytes, piece_is_read,
//          |     | member_offline, last_piece
//  csr     | in  | apb register writes and reads
//
//  a request enters in any cycle the pipeline advances; its first piece beat
//  passes the input stage, 15 divider stages and the piece sequencer; pieces
//  go out one per cycle while rsp is not stalled, 1 to 17 per request, and the
//  next request loads as the last piece leaves; synchronous active-high reset
//  resets valid bits, busy and csr settings; a stalled rsp stalls the pipeline
//  once the divider output holds a request, nothing is dropped or repeated
`default_nettype none
module raid0_stripe_request_splitter
   import r0ss_pkg::*;
#(
   parameter int MAX_MEMBERS        = 16,
   parameter int MAX_TRANSFER_BYTES = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   r0ss_req_if.sink         req_bus,
   r0ss_rsp_if.source       rsp_bus,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   cfg_type       cfg;
   logic          adv, div_valid, piece_ready;
   div_stage_type div_out;
   logic          stg_valid_ff;
   div_stage_type stg_ff, stg_in;
   logic [4:0]    sh;
   logic [11:0]   offmask;
   logic [56:0]   byteaddr;

   r0ss_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready, .cfg
   );

   always_comb begin
      if (cfg.strip_shift < 5'(SHIFT_MIN))      sh = 5'(SHIFT_MIN);
      else if (cfg.strip_shift > 5'(SHIFT_MAX)) sh = 5'(SHIFT_MAX);
      else                                      sh = cfg.strip_shift;
      byteaddr    = {req_bus.logical_block, 9'd0};
      offmask     = (12'd1 << (sh - 5'd9)) - 12'd1;
      stg_in.num  = SNO_W'(byteaddr >> sh);
      stg_in.rem  = '0;
      stg_in.offb = req_bus.logical_block[OFFB_W-1:0] & offmask[OFFB_W-1:0];
      stg_in.sh   = sh;
      if (cfg.member_count < 5'd2)                         stg_in.n = 5'd2;
      else if (32'(cfg.member_count) > 32'(MAX_MEMBERS))   stg_in.n = CNT_W'(MAX_MEMBERS);
      else                                                 stg_in.n = cfg.member_count;
      if (32'(req_bus.request_bytes) > 32'(MAX_TRANSFER_BYTES))
         stg_in.left = BYTES_W'(MAX_TRANSFER_BYTES);
      else
         stg_in.left = req_bus.request_bytes;
      stg_in.rd   = req_bus.is_read;
   end

   assign adv           = !div_valid || piece_ready;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) stg_valid_ff <= 1'b0;
      else if (adv) stg_valid_ff <= req_bus.valid;
   end

   always_ff @(posedge clock) begin
      if (adv) stg_ff <= stg_in;
   end

   r0ss_div u_div (
      .clock, .reset, .adv,
      .in_valid  (stg_valid_ff),
      .in_data   (stg_ff),
      .out_valid (div_valid),
      .out_data  (div_out)
   );

   r0ss_piece u_piece (
      .clock, .reset, .cfg,
      .in_valid (div_valid),
      .in_data  (div_out),
      .in_ready (piece_ready),
      .rsp      (rsp_bus)
   );

endmodule
`default_nettype wire

// File: bench/tb_raid0_stripe_request_splitter.sv
`timescale 1ns / 1ps
module tb_raid0_stripe_request_splitter;
   import r0ss_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   r0ss_req_if req_bus ();
   r0ss_rsp_if rsp_bus ();

   raid0_stripe_request_splitter dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   typedef struct {
      logic [LBLK_W-1:0]  lblk;
      logic [BYTES_W-1:0] nbytes;
      logic               rd;
      bit                 typed;
      rsp_type            want;
   } req_row_type;

   cfg_type     cfg_now;
   rsp_type     pieces_due[$];
   int          errors = 0;
   int          pieces_seen = 0;
   int          reqs_sent = 0;
   int          offline_seen = 0;
   bit          calm = 0;
   req_row_type rows[$];

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   initial begin
      #5ms;
      $display("timeout with %0d pieces outstanding", pieces_due.size());
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // splits one request over the stripe set as the block should
   task automatic split_request(input logic [LBLK_W-1:0] lblk,
                                input logic [BYTES_W-1:0] nbytes, input logic rd);
      longint unsigned sh, n, left, strip, sno, off, member, row, pblk, len;
      bit              online, done;
      int              k;
      rsp_type         p;
      sh = cfg_now.strip_shift;
      n = cfg_now.member_count;
      left = nbytes;
      k = 0;
      if (sh < SHIFT_MIN) sh = SHIFT_MIN;
      if (sh > SHIFT_MAX) sh = SHIFT_MAX;
      if (n < 2) n = 2;
      if (n > 16) n = 16;
      if (left > 65536) left = 65536;
      strip = 64'd1 << sh;
      sno = (longint'(lblk) << 9) >> sh;
      off = (longint'(lblk) << 9) & (strip - 1);
      forever begin
         member = sno % n;
         row = sno / n;
         pblk = (((row << sh) + off) >> 9) + cfg_now.data_offset_blocks;
         len = strip - off;
         online = member < 16 && cfg_now.member_online_mask[member[3:0]];
         if (len > left) len = left;
         p.member_index = member[3:0];
         p.physical_block = pblk[PBLK_W-1:0];
         p.piece_is_read = rd;
         if (!online) begin
            p.piece_bytes = '0;
            p.member_offline = 1'b1;
            p.last_piece = 1'b1;
            pieces_due.push_back(p);
            return;
         end
         left -= len;
         done = (left == 0) || (k + 1 >= MAX_RESULTS);
         p.piece_bytes = len[BYTES_W-1:0];
         p.member_offline = 1'b0;
         p.last_piece = done;
         pieces_due.push_back(p);
         k++;
         if (done) return;
         off = 0;
         sno++;
      end
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      logic [31:0] rd_want;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 4'(4 * int'(idx));
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // read the register back
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         CSR_STRIP_SHIFT:  cfg_now.strip_shift = value[4:0];
         CSR_MEMBER_COUNT: cfg_now.member_count = value[4:0];
         CSR_DATA_OFFSET:  cfg_now.data_offset_blocks = value;
         CSR_ONLINE_MASK:  cfg_now.member_online_mask = value[15:0];
         default: ;
      endcase
      case (idx)
         CSR_STRIP_SHIFT:  rd_want = {27'd0, value[4:0]};
         CSR_MEMBER_COUNT: rd_want = {27'd0, value[4:0]};
         CSR_DATA_OFFSET:  rd_want = value;
         CSR_ONLINE_MASK:  rd_want = {16'd0, value[15:0]};
         default:          rd_want = '0;
      endcase
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_pready !== 1'b1)
         report("csr_pready", 64'(csr_pready), 64'd1);
      if (csr_prdata !== rd_want)
         report("csr_prdata", 64'(csr_prdata), 64'(rd_want));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_stripe(input logic [4:0] sh, input logic [4:0] n,
                             input logic [31:0] offs, input logic [15:0] mask);
      csr_write(CSR_STRIP_SHIFT, 32'(sh));
      csr_write(CSR_MEMBER_COUNT, 32'(n));
      csr_write(CSR_DATA_OFFSET, offs);
      csr_write(CSR_ONLINE_MASK, 32'(mask));
   endtask

   task automatic drain;
      wait (pieces_due.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   // one request beat, sometimes after a random idle gap; valid then stays high unless the caller idles
   task automatic send_request(input logic [LBLK_W-1:0] lblk,
                               input logic [BYTES_W-1:0] nbytes, input logic rd,
                               input bit typed, input rsp_type want);
      if (!calm && $urandom_range(99) < 30) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.logical_block <= lblk;
      req_bus.request_bytes <= nbytes;
      req_bus.is_read <= rd;
      do @(posedge clock); while (!req_bus.ready);
      if (typed) pieces_due.push_back(want);
      else split_request(lblk, nbytes, rd);
      reqs_sent++;
   endtask

   task automatic random_request(input int strip_bias);
      logic [LBLK_W-1:0]  lblk;
      logic [BYTES_W-1:0] nbytes;
      rsp_type            none;
      int                 pick;
      none = '0;
      lblk = {$urandom(), $urandom()};
      pick = $urandom_range(99);
      if (pick < 20) lblk = 48'(($urandom_range(0, 1 << 14) << strip_bias))
                            - 48'($urandom_range(0, 3));
      pick = $urandom_range(99);
      if (pick < 35) nbytes = 17'($urandom_range(1, 4096));
      else if (pick < 80) nbytes = 17'($urandom_range(4097, 65536));
      else if (pick < 88) nbytes = 17'd65536;
      else if (pick < 94) nbytes = 17'($urandom_range(65537, 131071));
      else nbytes = 17'($urandom_range(0, 1));
      send_request(lblk, nbytes, 1'($urandom()), 1'b0, none);
   endtask

   always @(posedge clock) begin
      rsp_type p;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         pieces_seen++;
         if (pieces_due.size() == 0) begin
            report("unexpected piece beat", 64'(rsp_bus.physical_block), 64'd0);
         end else begin
            p = pieces_due.pop_front();
            if (rsp_bus.member_index !== p.member_index)
               report("member_index", 64'(rsp_bus.member_index), 64'(p.member_index));
            if (rsp_bus.physical_block !== p.physical_block)
               report("physical_block", 64'(rsp_bus.physical_block), 64'(p.physical_block));
            if (rsp_bus.piece_bytes !== p.piece_bytes)
               report("piece_bytes", 64'(rsp_bus.piece_bytes), 64'(p.piece_bytes));
            if (rsp_bus.piece_is_read !== p.piece_is_read)
               report("piece_is_read", 64'(rsp_bus.piece_is_read), 64'(p.piece_is_read));
            if (rsp_bus.member_offline !== p.member_offline)
               report("member_offline", 64'(rsp_bus.member_offline), 64'(p.member_offline));
            if (rsp_bus.last_piece !== p.last_piece)
               report("last_piece", 64'(rsp_bus.last_piece), 64'(p.last_piece));
            if (p.member_offline) offline_seen++;
         end
      end
      rsp_bus.ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
   end

   initial begin
      rsp_type none;
      none = '0;
      reset <= 1'b1;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.logical_block <= '0;
      req_bus.request_bytes <= '0;
      req_bus.is_read <= 1'b0;
      cfg_now = '{strip_shift: 5'd16, member_count: 5'd2, data_offset_blocks: 32'd0,
                  member_online_mask: 16'hFFFF};
      // reset geometry: 64 KiB strips over two members
      rows = '{
         '{48'd0,   17'd1,     1'b1, 1'b1, rsp_type'{4'd0, 49'd0, 17'd1, 1'b1, 1'b0, 1'b1}},
         '{48'd0,   17'd65536, 1'b0, 1'b1, rsp_type'{4'd0, 49'd0, 17'd65536, 1'b0, 1'b0, 1'b1}},
         '{48'd0,   17'd0,     1'b0, 1'b1, rsp_type'{4'd0, 49'd0, 17'd0, 1'b0, 1'b0, 1'b1}},
         '{48'd128, 17'd512,   1'b1, 1'b1, rsp_type'{4'd1, 49'd0, 17'd512, 1'b1, 1'b0, 1'b1}},
         '{48'd256, 17'd4096,  1'b0, 1'b1, rsp_type'{4'd0, 49'd128, 17'd4096, 1'b0, 1'b0, 1'b1}},
         '{48'hFFFF_FFFF_FFFF, 17'd1,       1'b1, 1'b0, none},
         '{48'hFFFF_FFFF_FFFF, 17'h1FFFF,   1'b0, 1'b0, none},
         '{48'hFFFF_FFFF_FF80, 17'd65536,   1'b1, 1'b0, none},
         '{48'd127, 17'd1024,  1'b0, 1'b0, none},
         '{48'd100, 17'd65536, 1'b1, 1'b0, none},
         '{48'd255, 17'd65537, 1'b0, 1'b0, none},
         '{48'hAAAA_AAAA_AAAA, 17'h15555, 1'b1, 1'b0, none},
         '{48'h5555_5555_5555, 17'h0AAAA, 1'b0, 1'b0, none}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i])
         send_request(rows[i].lblk, rows[i].nbytes, rows[i].rd, rows[i].typed, rows[i].want);
      req_bus.valid <= 1'b0;
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            0: set_stripe(5'd12, 5'd16, 32'hFFFF_FFFF, 16'hFFFF);
            1: set_stripe(5'd20, 5'd2, 32'd0, 16'h0001);
            2: set_stripe(5'd0, 5'd0, $urandom(), 16'($urandom()));
            3: set_stripe(5'd31, 5'd31, 32'd7, 16'hFFFF);
            4: set_stripe(5'd12, 5'd3, 32'd0, 16'h0000);
            default: set_stripe(5'($urandom_range(10, 22)), 5'($urandom_range(1, 17)),
                                $urandom(), 16'hFFFF ^ (16'd1 << $urandom_range(0, 15))
                                ^ (($urandom_range(1) != 0) ? 16'd0 : 16'($urandom())));
         endcase
         calm = (ph == 3);
         for (int i = 0; i < 48; i++) begin
            random_request(int'(cfg_now.strip_shift) - 9);
            if (ph == 1 && i == 10) begin
               // hold the sender until everything has come back
               req_bus.valid <= 1'b0;
               wait (pieces_due.size() == 0);
               @(posedge clock);
            end
         end
         req_bus.valid <= 1'b0;
         calm = 0;
         drain();
      end

      $display("sent %0d requests over 10 stripe settings, checked %0d piece beats",
               reqs_sent, pieces_seen);
      $display("offline aborts seen: %0d", offline_seen);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/r0ss_pkg.sv
design/r0ss_chan_if.sv
design/r0ss_csr.sv
design/r0ss_div.sv
design/r0ss_piece.sv
design/raid0_stripe_request_splitter.sv
bench/tb_raid0_stripe_request_splitter.sv
